>>> sv/lse_pkg.sv
// Shared constants and types for the LIFO stack engine.
// Holds store sizing, command codes and status codes. No dependencies.
package lse_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_status;

    localparam t_cmd CMD_PUSH = 3'd0;
    localparam t_cmd CMD_POP  = 3'd1;
    localparam t_cmd CMD_SWAP = 3'd2;
    localparam t_cmd CMD_PEEK = 3'd3;
    localparam t_cmd CMD_DUMP = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_SHORT = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

endpackage

>>> sv/lifo_stack_engine.sv
// Bounded LIFO stack of signed 32-bit entries held in one synchronous store.
// Uses lse_pkg for sizing, command and status codes.
//
// Usage:
//   Input channel: i_valid / o_stall carry one command beat (i_cmd,
//   i_push_value). Output channel: o_valid / i_stall carry result beats
//   (o_status, o_has_value, o_value, o_last).
//   Push, pop, swap and unknown commands produce one status beat; peek one
//   beat with the top entry; dump one beat per entry, top first, o_last on
//   the bottom entry (a single empty beat when the stack is empty).
//   The first result beat is loaded into the output register in S_EMIT, entered
//   straight after the command is taken, or after S_SWAP1, S_SWAP2 and S_SWAP3
//   for swap. The engine takes no new command until it is back in idle after
//   its last beat; swap reads and then writes back the two top entries in turn.
//   The next command is taken while the last result still waits.
//   When i_stall is high the output register holds its beat and the engine
//   waits with its pending result; no beat is dropped.
//   Reset (i_rst_n low, synchronous) empties the stack, returns to idle and
//   clears the output valid flag. The store itself is not cleared.
module lifo_stack_engine
    import lse_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_status,
    output logic                     o_has_value,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EMIT  = 3'd1;
    localparam logic [2:0] S_SWAP1 = 3'd2;
    localparam logic [2:0] S_SWAP2 = 3'd3;
    localparam logic [2:0] S_SWAP3 = 3'd4;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_status           r_st, n_st;
    logic              r_has, n_has;
    logic              r_dump, n_dump;
    logic [DATA_W-1:0] r_tmp, n_tmp;

    logic              r_ovalid, n_ovalid;
    t_status           r_ostatus, n_ostatus;
    logic              r_ohas, n_ohas;
    logic [DATA_W-1:0] r_ovalue, n_ovalue;
    logic              r_olast, n_olast;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              in_beat;
    logic              out_free;
    logic [ADDR_W-1:0] top_idx;

    assign o_stall  = (r_state != S_IDLE);
    assign in_beat  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_stall;
    assign top_idx  = ADDR_W'(r_cnt - CNT_W'(1));

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_st      = r_st;
        n_has     = r_has;
        n_dump    = r_dump;
        n_tmp     = r_tmp;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ohas    = r_ohas;
        n_ovalue  = r_ovalue;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rd;
        mem_re    = 1'b0;
        mem_raddr = top_idx;

        // retire the held beat once the receiver takes it
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_st    = ST_OK;
                    n_has   = 1'b0;
                    n_dump  = 1'b0;
                    n_idx   = top_idx;
                    n_state = S_EMIT;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_cnt[ADDR_W-1:0];
                                mem_wdata = i_push_value;
                                n_cnt     = r_cnt + CNT_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_cnt == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_cnt = r_cnt - CNT_W'(1);
                            end
                        end
                        CMD_SWAP: begin
                            if (r_cnt < CNT_W'(2)) begin
                                n_st = ST_SHORT;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_SWAP1;
                            end
                        end
                        CMD_PEEK: begin
                            if (r_cnt == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                mem_re = 1'b1;
                                n_has  = 1'b1;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_cnt == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                mem_re = 1'b1;
                                n_has  = 1'b1;
                                n_dump = 1'b1;
                            end
                        end
                        default: begin
                            n_st = ST_OK;
                        end
                    endcase
                end
            end
            S_SWAP1: begin
                // hold the top entry, fetch the one below it
                n_tmp     = r_rd;
                mem_re    = 1'b1;
                mem_raddr = r_idx - ADDR_W'(1);
                n_state   = S_SWAP2;
            end
            S_SWAP2: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rd;
                n_state   = S_SWAP3;
            end
            S_SWAP3: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx - ADDR_W'(1);
                mem_wdata = r_tmp;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_st;
                    n_ohas    = r_has;
                    n_ovalue  = r_has ? r_rd : '0;
                    n_olast   = !r_dump || (r_idx == '0);
                    if (r_dump && (r_idx != '0)) begin
                        // advance to the next entry down
                        n_idx     = r_idx - ADDR_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = r_idx - ADDR_W'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_dump   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_dump   <= n_dump;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_st      <= n_st;
        r_has     <= n_has;
        r_tmp     <= n_tmp;
        r_ostatus <= n_ostatus;
        r_ohas    <= n_ohas;
        r_ovalue  <= n_ovalue;
        r_olast   <= n_olast;
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_has_value = r_ohas;
    assign o_value     = r_ovalue;
    assign o_last      = r_olast;

endmodule

>>> tb/lifo_stack_engine_tb.sv
// Self-checking bench for lifo_stack_engine: command beats in, result beats checked
// against a behavioural stack kept alongside. Depends on lse_pkg and the RTL only.
module lifo_stack_engine_tb;
    import lse_pkg::*;

    localparam t_cmd CMD_CODE_MAX = 3'd7;
    localparam int   IDLE_LIMIT   = 3000;
    localparam int   DRAIN_CYCLES = 20;

    typedef struct {
        bit                       hold;
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] val;
    } t_cmd_beat;

    typedef struct {
        t_status                  status;
        logic                     has_value;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_result_beat;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_stall;
    logic [2:0]               i_cmd        = '0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     o_valid;
    logic                     i_stall      = 1'b0;
    logic [1:0]               o_status;
    logic                     o_has_value;
    logic signed [DATA_W-1:0] o_value;
    logic                     o_last;

    t_cmd_beat    cmd_queue[$];
    t_result_beat results_due[$];

    logic signed [DATA_W-1:0] stack_mem [DEPTH];
    int unsigned              stack_fill  = 0;
    int unsigned              gen_fill    = 0;
    int                       queued_cmds = 0;
    int                       fail_count  = 0;
    int                       idle_cycles = 0;
    int                       burst_left  = 0;
    int                       gap_left    = 0;
    int                       stall_left  = 0;
    t_rx_mode                 stall_mode  = RX_FREE;
    logic                     cmd_taken   = 1'b0;
    logic                     stim_done   = 1'b0;

    lifo_stack_engine u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_has_value  (o_has_value),
        .o_value      (o_value),
        .o_last       (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Apply one command to the behavioural stack and queue the beats it yields.
    function automatic void predict_stack_results(input t_cmd cmd,
                                                  input logic signed [DATA_W-1:0] val);
        t_result_beat             r;
        logic signed [DATA_W-1:0] tmp;
        r = '{ST_OK, 1'b0, 32'sd0, 1'b1};
        case (cmd)
            CMD_PUSH: begin
                if (stack_fill == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_mem[stack_fill] = val;
                    stack_fill++;
                end
            end
            CMD_POP: begin
                if (stack_fill == 0) r.status = ST_EMPTY;
                else stack_fill--;
            end
            CMD_SWAP: begin
                if (stack_fill < 2) begin
                    r.status = ST_SHORT;
                end else begin
                    tmp                     = stack_mem[stack_fill-1];
                    stack_mem[stack_fill-1] = stack_mem[stack_fill-2];
                    stack_mem[stack_fill-2] = tmp;
                end
            end
            CMD_PEEK: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.has_value = 1'b1;
                    r.value     = stack_mem[stack_fill-1];
                end
            end
            CMD_DUMP: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // top first, last flag on the bottom entry only
                    for (int k = stack_fill - 1; k >= 0; k--) begin
                        results_due.push_back('{ST_OK, 1'b1, stack_mem[k], k == 0});
                    end
                    return;
                end
            end
            default: ;
        endcase
        results_due.push_back(r);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed(DATA_W'($urandom_range(0, 15))) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_cmd pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return CMD_PUSH;
        if (r < 55) return CMD_POP;
        if (r < 70) return CMD_SWAP;
        if (r < 82) return CMD_PEEK;
        if (r < 90) return CMD_DUMP;
        return t_cmd'($urandom_range(CMD_DUMP + 1, CMD_CODE_MAX));
    endfunction

    // Track the fill level while queueing so that full and empty can be aimed at.
    function automatic void add_cmd(input t_cmd cmd, input logic signed [DATA_W-1:0] val);
        cmd_queue.push_back('{1'b0, cmd, val});
        queued_cmds++;
        if (cmd == CMD_PUSH && gen_fill < DEPTH) gen_fill++;
        if (cmd == CMD_POP && gen_fill > 0) gen_fill--;
    endfunction

    function automatic void add_hold();
        cmd_queue.push_back('{1'b1, CMD_PUSH, 32'sd0});
    endfunction

    // Result side check and prediction, both on the rising edge.
    always @(posedge i_clk) begin
        t_result_beat want;
        cmd_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending, value %0d",
                                              o_value));
                end else begin
                    want = results_due.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                    if (o_has_value !== want.has_value)
                        report_mismatch($sformatf("has_value %0b, want %0b",
                                                  o_has_value, want.has_value));
                    if (o_value !== want.value)
                        report_mismatch($sformatf("value %0d, want %0d",
                                                  o_value, want.value));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  o_last, want.last));
                end
            end
            if (i_valid && !o_stall) predict_stack_results(i_cmd, i_push_value);
        end
    end

    // Command driver: bursts with gaps, advance only once the held beat is taken.
    always @(negedge i_clk) begin
        t_cmd_beat nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || cmd_taken) begin
            if (cmd_queue.size() == 0) begin
                i_valid   <= 1'b0;
                stim_done <= 1'b1;
            end else if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_queue[0].hold) begin
                // hold off until every pending result has drained
                i_valid <= 1'b0;
                if (results_due.size() == 0) void'(cmd_queue.pop_front());
            end else begin
                nxt = cmd_queue.pop_front();
                i_valid      <= 1'b1;
                i_cmd        <= nxt.cmd;
                i_push_value <= nxt.val;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver back-pressure: free, random and periodic stretches.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left == 0) begin
            stall_mode <= t_rx_mode'($urandom_range(0, 2));
            stall_left <= $urandom_range(4, 40);
            i_stall    <= 1'b0;
        end else begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                default:   i_stall <= (stall_left % 8) < 5;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("lifo_stack_engine_tb: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        bit filled;
        bit drained;
        int unsigned n;

        // empty-stack cases, single- and two-entry swap, the value extremes and unknown codes
        add_cmd(CMD_DUMP, pick_value());
        add_cmd(CMD_PEEK, pick_value());
        add_cmd(CMD_POP, pick_value());
        add_cmd(CMD_SWAP, pick_value());
        add_cmd(CMD_PUSH, 32'sh7FFF_FFFF);
        add_cmd(CMD_SWAP, pick_value());
        add_cmd(CMD_PEEK, pick_value());
        add_cmd(CMD_PUSH, 32'sh8000_0000);
        add_cmd(CMD_SWAP, pick_value());
        add_cmd(CMD_PEEK, pick_value());
        add_cmd(CMD_DUMP, pick_value());
        add_cmd(CMD_PUSH, 32'sd0);
        add_cmd(CMD_PUSH, -32'sd1);
        add_cmd(t_cmd'(CMD_DUMP + 1), pick_value());
        add_cmd(t_cmd'(CMD_DUMP + 2), pick_value());
        add_cmd(CMD_CODE_MAX, pick_value());
        add_cmd(CMD_POP, pick_value());
        add_cmd(CMD_PEEK, pick_value());
        add_cmd(CMD_DUMP, pick_value());
        while (gen_fill > 0) add_cmd(CMD_POP, pick_value());
        add_cmd(CMD_POP, pick_value());
        add_cmd(CMD_DUMP, pick_value());
        add_hold();

        filled  = 1'b0;
        drained = 1'b0;
        while (queued_cmds < 180) begin
            if (!filled && queued_cmds > 30) begin
                // run up to full, overflow, then read everything back
                while (gen_fill < DEPTH) add_cmd(CMD_PUSH, pick_value());
                repeat ($urandom_range(1, 2)) add_cmd(CMD_PUSH, pick_value());
                add_cmd(CMD_PEEK, pick_value());
                add_cmd(CMD_SWAP, pick_value());
                add_cmd(CMD_DUMP, pick_value());
                add_hold();
                filled = 1'b1;
            end else if (!drained && filled && queued_cmds > 130) begin
                while (gen_fill > 0) add_cmd(CMD_POP, pick_value());
                add_cmd(CMD_POP, pick_value());
                add_cmd(CMD_SWAP, pick_value());
                add_cmd(CMD_PEEK, pick_value());
                add_cmd(CMD_DUMP, pick_value());
                drained = 1'b1;
            end else begin
                n = $urandom_range(5, 15);
                repeat (n) add_cmd(pick_cmd(), pick_value());
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (!stim_done || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("lifo_stack_engine_tb: PASS");
        end else begin
            $display("lifo_stack_engine_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/lse_pkg.sv
sv/lifo_stack_engine.sv
tb/lifo_stack_engine_tb.sv
